// ===== hdl/pbgh_pkg.sv =====
package pbgh_pkg;

    localparam int NUM_TRACKS     = 6;
    localparam int NUM_BUCKETS    = 7;
    localparam int NUM_EDGES      = 6;
    localparam int NUM_TAG_TRACKS = 5;
    localparam int PROX_TRACK     = 5;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int BKT_ENTRIES    = NUM_TRACKS * NUM_BUCKETS;
    localparam int BKT_AW         = $clog2(BKT_ENTRIES);
    localparam int CFG_ADDR_W     = 5;

    typedef logic [2:0]                  track_t;
    typedef logic [3:0]                  stat_sel_t;
    typedef logic [NUM_TRACKS-1:0]       track_vec_t;
    typedef logic [BKT_AW-1:0]           bkt_addr_t;
    typedef logic [NUM_EDGES-1:0][15:0]  edge_set_t;

    localparam logic      KIND_READ        = 1'b1;
    localparam logic [7:0] ACCEPT_RNUM     = 8'h02;
    localparam logic [7:0] MIN_FRAME_LEN   = 8'd2;
    localparam logic [7:0] TAG_HI_MASK     = 8'hF0;
    localparam logic [7:0] TAG_OOR_HI      = 8'hB0;
    localparam logic [7:0] TAG_BIT4        = 8'h10;
    localparam logic [7:0] TAG_PROX_OUT    = 8'hC0;

    localparam logic [NUM_TAG_TRACKS-1:0][7:0] TAG_MASK =
        {8'h40, 8'h08, 8'h04, 8'h02, 8'h01};

    localparam edge_set_t EDGE_RESET =
        {16'd1000, 16'd300, 16'd150, 16'd80, 16'd40, 16'd20};

    localparam stat_sel_t STAT_RELEASES  = 4'd7;
    localparam stat_sel_t STAT_REASSERTS = 4'd8;
    localparam stat_sel_t STAT_MAX_GAP   = 4'd9;

    typedef struct packed {
        logic        is_stat;
        track_t      trk;
        stat_sel_t   sel;
        track_vec_t  mask;
        track_vec_t  down;
        logic [31:0] time_ms;
    } cmd_t;

    typedef struct packed {
        logic        is_stat;
        track_t      trk;
        stat_sel_t   sel;
        logic        down;
        logic        last;
        logic [31:0] held;
    } op_t;

endpackage

// ===== hdl/pbgh_ram.sv =====
module pbgh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 42
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/pbgh_front.sv =====
module pbgh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [63:0]    s_tdata,
    input  logic           s_tuser,
    input  logic           q_ready,
    output logic           push,
    output pbgh_pkg::cmd_t cmd
);
    import pbgh_pkg::*;

    logic        is_input_report;
    logic [7:0]  report_number;
    logic [7:0]  frame_length;
    logic [7:0]  tag_byte;
    logic [31:0] time_ms;
    track_t      track_select;
    stat_sel_t   stat_select;
    logic        accept;
    logic        is_read;
    logic        frame_ok;
    track_vec_t  down_reg;
    track_vec_t  down_next;
    track_vec_t  change;

    assign is_input_report = s_tdata[0];
    assign report_number   = s_tdata[8:1];
    assign frame_length    = s_tdata[16:9];
    assign tag_byte        = s_tdata[24:17];
    assign time_ms         = s_tdata[56:25];
    assign track_select    = s_tdata[59:57];
    assign stat_select     = s_tdata[63:60];

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;
    assign is_read  = (s_tuser == KIND_READ);

    assign frame_ok = is_input_report
                   && (report_number == ACCEPT_RNUM)
                   && (frame_length >= MIN_FRAME_LEN)
                   && ((tag_byte & TAG_HI_MASK) != TAG_OOR_HI)
                   && ((tag_byte & TAG_BIT4) == 8'h00);

    always_comb
    begin
        down_next = down_reg;
        if (tag_byte == TAG_PROX_OUT)
        begin
            down_next[PROX_TRACK] = 1'b0;
        end
        else
        begin
            down_next[PROX_TRACK] = 1'b1;
            for (int i = 0; i < NUM_TAG_TRACKS; i++)
            begin
                down_next[i] = ((tag_byte & TAG_MASK[i]) != 8'h00);
            end
        end
    end

    assign change = down_next ^ down_reg;
    assign push   = accept && (is_read || (frame_ok && (change != '0)));

    always_comb
    begin
        cmd.is_stat = is_read;
        cmd.trk     = track_select;
        cmd.sel     = stat_select;
        cmd.mask    = is_read ? '0 : change;
        cmd.down    = down_next;
        cmd.time_ms = time_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= '0;
        end
        else if (accept && !is_read && frame_ok)
        begin
            down_reg <= down_next;
        end
    end

endmodule

// ===== hdl/pbgh_queue.sv =====
module pbgh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pbgh_pkg::cmd_t push_cmd,
    output logic           ready,
    output logic           valid,
    output pbgh_pkg::cmd_t head,
    input  logic           pop
);
    import pbgh_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign ready   = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/pbgh_back.sv =====
module pbgh_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pbgh_pkg::edge_set_t edges,
    input  logic                q_valid,
    input  pbgh_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import pbgh_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t c);
        return (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // sequencer
    track_vec_t  done_reg;
    track_vec_t  pending;
    track_vec_t  pick_bit;
    track_t      pick_trk;
    logic        final_op;
    op_t         seq_op;
    logic        take1;
    logic [31:0] last_edge_reg [NUM_TRACKS];

    // stage 1
    logic        v1_reg;
    op_t         op1_reg;
    logic        s1_ready;
    logic        adv2;
    logic [2:0]  bucket;
    bkt_addr_t   addr1;
    logic        zero1;
    logic        use_q1;

    // stage 2
    logic        v2_reg;
    op_t         op2_reg;
    bkt_addr_t   addr2_reg;
    logic        zero2_reg;
    logic        hit2_reg;
    cnt_t        fwd2_reg;
    logic        vbit2_reg;
    logic        s2_ready;
    logic        fire;
    logic        wr_en;
    cnt_t        ram_q;
    cnt_t        q_val;
    cnt_t        q_inc;
    cnt_t        cnt_pick;
    logic [63:0] wide;
    logic [31:0] stat32;
    logic [BKT_ENTRIES-1:0] bkt_valid_reg;
    cnt_t        rel_reg  [NUM_TRACKS];
    cnt_t        rea_reg  [NUM_TRACKS];
    logic [31:0] gap_reg  [NUM_TRACKS];

    // pick the next changed track: proximity first, then 0..4
    assign pending = q_cmd.mask & ~done_reg;

    always_comb
    begin
        pick_trk = track_t'(PROX_TRACK);
        if (!pending[PROX_TRACK])
        begin
            for (int i = NUM_TAG_TRACKS - 1; i >= 0; i--)
            begin
                if (pending[i])
                begin
                    pick_trk = track_t'(i);
                end
            end
        end
        pick_bit = track_vec_t'(1) << pick_trk;
        final_op = q_cmd.is_stat || ((pending & ~pick_bit) == '0);
    end

    always_comb
    begin
        seq_op.is_stat = q_cmd.is_stat;
        seq_op.trk     = q_cmd.is_stat ? q_cmd.trk : pick_trk;
        seq_op.sel     = q_cmd.sel;
        seq_op.down    = q_cmd.is_stat ? 1'b0 : q_cmd.down[pick_trk];
        seq_op.last    = final_op;
        seq_op.held    = q_cmd.is_stat ? 32'h0 : (q_cmd.time_ms - last_edge_reg[pick_trk]);
    end

    assign fire     = v2_reg && m_tready;
    assign s2_ready = !v2_reg || fire;
    assign adv2     = v1_reg && s2_ready;
    assign s1_ready = !v1_reg || s2_ready;
    assign take1    = q_valid && s1_ready;
    assign q_pop    = take1 && final_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
            for (int i = 0; i < NUM_TRACKS; i++)
            begin
                last_edge_reg[i] <= 32'h0;
            end
        end
        else if (take1)
        begin
            done_reg <= final_op ? '0 : (done_reg | pick_bit);
            if (!q_cmd.is_stat)
            begin
                last_edge_reg[pick_trk] <= q_cmd.time_ms;
            end
        end
    end

    // gap bucket and counter address
    always_comb
    begin
        bucket = 3'(NUM_BUCKETS - 1);
        for (int i = NUM_EDGES - 1; i >= 0; i--)
        begin
            if (op1_reg.held < {16'h0, edges[i]})
            begin
                bucket = 3'(i);
            end
        end
        zero1  = op1_reg.is_stat
              && ((op1_reg.trk >= track_t'(NUM_TRACKS)) || (op1_reg.sel > STAT_MAX_GAP));
        use_q1 = op1_reg.is_stat ? (!zero1 && (op1_reg.sel < stat_sel_t'(NUM_BUCKETS)))
                                 : op1_reg.down;
        if (!use_q1)
        begin
            addr1 = '0;
        end
        else if (op1_reg.is_stat)
        begin
            addr1 = BKT_AW'(op1_reg.trk) * BKT_AW'(NUM_BUCKETS) + BKT_AW'(op1_reg.sel);
        end
        else
        begin
            addr1 = BKT_AW'(op1_reg.trk) * BKT_AW'(NUM_BUCKETS) + BKT_AW'(bucket);
        end
    end

    assign wr_en = fire && !op2_reg.is_stat && op2_reg.down;

    pbgh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BKT_ENTRIES)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr2_reg),
        .wdata (q_inc),
        .re    (adv2),
        .raddr (addr1),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                v1_reg <= q_valid;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            op1_reg <= seq_op;
        end
        if (adv2)
        begin
            op2_reg   <= op1_reg;
            addr2_reg <= addr1;
            zero2_reg <= zero1;
            hit2_reg  <= wr_en && (addr2_reg == addr1);
            fwd2_reg  <= q_inc;
            vbit2_reg <= bkt_valid_reg[addr1];
        end
    end

    // forward a counter written in the same cycle it is read back
    assign q_val = hit2_reg ? fwd2_reg : (vbit2_reg ? ram_q : '0);
    assign q_inc = sat_inc(q_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_valid_reg <= '0;
            for (int i = 0; i < NUM_TRACKS; i++)
            begin
                rel_reg[i] <= '0;
                rea_reg[i] <= '0;
                gap_reg[i] <= 32'h0;
            end
        end
        else if (fire && !op2_reg.is_stat)
        begin
            if (op2_reg.down)
            begin
                bkt_valid_reg[addr2_reg] <= 1'b1;
                rea_reg[op2_reg.trk]     <= sat_inc(rea_reg[op2_reg.trk]);
                if (op2_reg.held > gap_reg[op2_reg.trk])
                begin
                    gap_reg[op2_reg.trk] <= op2_reg.held;
                end
            end
            else
            begin
                rel_reg[op2_reg.trk] <= sat_inc(rel_reg[op2_reg.trk]);
            end
        end
    end

    always_comb
    begin
        cnt_pick = '0;
        wide     = 64'h0;
        stat32   = 32'h0;
        if (op2_reg.is_stat && !zero2_reg)
        begin
            if (op2_reg.sel == STAT_MAX_GAP)
            begin
                stat32 = gap_reg[op2_reg.trk];
            end
            else
            begin
                if (op2_reg.sel == STAT_RELEASES)
                begin
                    cnt_pick = rel_reg[op2_reg.trk];
                end
                else if (op2_reg.sel == STAT_REASSERTS)
                begin
                    cnt_pick = rea_reg[op2_reg.trk];
                end
                else
                begin
                    cnt_pick = q_val;
                end
                wide   = 64'(cnt_pick);
                stat32 = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            end
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tuser  = op2_reg.is_stat;
    assign m_tlast  = op2_reg.last;
    assign m_tdata  = op2_reg.is_stat ? {4'h0, stat32, 36'h0}
                                      : {4'h0, 32'h0, op2_reg.held, op2_reg.down, op2_reg.trk};

endmodule

// ===== hdl/pen_bit_gap_histogram_top.sv =====
// Channel   Role      Handshake                  Contents
// s_*       requests  s_tvalid / s_tready        frames and statistic reads
// m_*       results   m_tvalid / m_tready        transition events and read results
// apb       config    psel, penable, pready=1    bucket edges 0..5 at 0x00..0x14
//
// One request is taken per cycle while the four-entry queue has room.
// The back end issues one result per cycle while m_tready is high: a frame changing k tracks
// gives k results, a read gives one.
// Reset clears track state, edge times, counters and counter valid bits; edges reload.
// m_tready low holds the result stage; the queue absorbs up to four requests.
module pen_bit_gap_histogram_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // is_input_report, report_number, frame_length, tag_byte, time_ms,
    // track_select, stat_select
    input  logic [63:0]                   s_tdata,
    // kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // event_track, went_down, duration_ms, stat_value, zero pad
    output logic [71:0]                   m_tdata,
    // is_stat
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbgh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pbgh_pkg::*;

    edge_set_t  edge_reg;
    logic [2:0] cfg_idx;
    logic       cfg_wr;
    logic       q_ready;
    logic       push;
    cmd_t       push_cmd;
    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx < 3'(NUM_EDGES)) ? {16'h0, edge_reg[cfg_idx]} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= EDGE_RESET;
        end
        else if (cfg_wr && (cfg_idx < 3'(NUM_EDGES)))
        begin
            edge_reg[cfg_idx] <= pwdata[15:0];
        end
    end

    pbgh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .push     (push),
        .cmd      (push_cmd)
    );

    pbgh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .valid    (q_valid),
        .head     (q_cmd),
        .pop      (q_pop)
    );

    pbgh_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .edges    (edge_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_frame_has_change: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_cmd.is_stat) |-> (q_cmd.mask != '0))
        else $error("queued frame carries no track change");

    a_stat_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[35:0] == 36'h0)))
        else $error("read result not final or has event fields");

    a_event_no_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[67:36] == 32'h0))
        else $error("event carries a statistic value");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

// ===== tb/tb_pen_bit_gap_histogram_top.sv =====
module tb_pen_bit_gap_histogram_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pbgh_pkg::*;

    localparam int          CNT_W      = 32;
    localparam logic [63:0] CNT_MAX    = (64'd1 << CNT_W) - 64'd1;
    localparam int          LIMIT      = 200000;
    localparam int          SETTLE     = 12;
    localparam int          HOLD_LEN   = 300;
    localparam int          NUM_PHASES = 5;
    localparam int          PHASE_LEN  = 56;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_READ} check_mode_e;

    // packed from the top down, so is_input sits in bit 0
    typedef struct packed {
        stat_sel_t   stat_sel;
        track_t      trk_sel;
        logic [31:0] time_ms;
        logic [7:0]  tag;
        logic [7:0]  len;
        logic [7:0]  rnum;
        logic        is_input;
    } req_t;

    typedef struct {
        logic        kind;
        req_t        req;
        check_mode_e mode;
        logic [31:0] typed_val;
    } vec_t;

    typedef struct {
        logic        is_stat;
        track_t      trk;
        logic        down;
        logic [31:0] dur;
        logic [31:0] val;
        logic        is_last;
    } result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    pen_bit_gap_histogram_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [15:0] bkt_edges    [NUM_EDGES];
    logic        track_state  [NUM_TRACKS];
    logic [31:0] edge_time    [NUM_TRACKS];
    logic [63:0] bucket_cnt   [BKT_ENTRIES];
    logic [63:0] release_cnt  [NUM_TRACKS];
    logic [63:0] reassert_cnt [NUM_TRACKS];
    logic [31:0] gap_max      [NUM_TRACKS];

    result_t     step_results [$];
    result_t     expected_results [$];
    result_t     want_res;
    vec_t        directed [$];

    int          mismatch_count = 0;
    int          req_count      = 0;
    int          result_count   = 0;
    int          event_count    = 0;
    int          read_count     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    logic [31:0] cur_time       = 32'd2000;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [63:0] sat_inc(input logic [63:0] c);
        return (c < CNT_MAX) ? c + 64'd1 : c;
    endfunction

    function automatic void gap_reset();
        for (int i = 0; i < NUM_EDGES; i++)
            bkt_edges[i] = EDGE_RESET[i];
        for (int i = 0; i < NUM_TRACKS; i++)
        begin
            track_state[i]  = 1'b0;
            edge_time[i]    = '0;
            release_cnt[i]  = '0;
            reassert_cnt[i] = '0;
            gap_max[i]      = '0;
        end
        for (int i = 0; i < BKT_ENTRIES; i++)
            bucket_cnt[i] = '0;
    endfunction

    function automatic void track_edge(input int trk, input logic down, input logic [31:0] t);
        logic [31:0] held;
        int          b;
        result_t     r;
        if (down == track_state[trk])
            return;
        held = t - edge_time[trk];
        if (down)
        begin
            reassert_cnt[trk] = sat_inc(reassert_cnt[trk]);
            b = 0;
            while (b < NUM_EDGES && held >= {16'h0, bkt_edges[b]})
                b++;
            bucket_cnt[trk*NUM_BUCKETS+b] = sat_inc(bucket_cnt[trk*NUM_BUCKETS+b]);
            if (held > gap_max[trk])
                gap_max[trk] = held;
        end
        else
            release_cnt[trk] = sat_inc(release_cnt[trk]);
        track_state[trk] = down;
        edge_time[trk]   = t;
        r.is_stat = 1'b0;
        r.trk     = track_t'(trk);
        r.down    = down;
        r.dur     = held;
        r.val     = '0;
        r.is_last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void predict_gaps(input logic kind, input req_t req);
        logic [63:0] v;
        result_t     r;
        step_results.delete();
        if (kind == KIND_READ)
        begin
            v = '0;
            if (req.trk_sel < NUM_TRACKS)
            begin
                if (req.stat_sel < NUM_BUCKETS)
                    v = bucket_cnt[req.trk_sel*NUM_BUCKETS+req.stat_sel];
                else if (req.stat_sel == STAT_RELEASES)
                    v = release_cnt[req.trk_sel];
                else if (req.stat_sel == STAT_REASSERTS)
                    v = reassert_cnt[req.trk_sel];
                else if (req.stat_sel == STAT_MAX_GAP)
                    v = {32'h0, gap_max[req.trk_sel]};
            end
            if (v > 64'hFFFF_FFFF)
                v = 64'hFFFF_FFFF;
            r.is_stat = 1'b1;
            r.trk     = '0;
            r.down    = 1'b0;
            r.dur     = '0;
            r.val     = v[31:0];
            r.is_last = 1'b1;
            step_results.push_back(r);
            return;
        end
        if (req.is_input != 1'b1 || req.rnum != ACCEPT_RNUM || req.len < MIN_FRAME_LEN)
            return;
        if ((req.tag & TAG_HI_MASK) == TAG_OOR_HI || (req.tag & TAG_BIT4) != 8'h0)
            return;
        if (req.tag == TAG_PROX_OUT)
            track_edge(PROX_TRACK, 1'b0, req.time_ms);
        else
        begin
            track_edge(PROX_TRACK, 1'b1, req.time_ms);
            for (int i = 0; i < NUM_TAG_TRACKS; i++)
                track_edge(i, (req.tag & TAG_MASK[i]) != 8'h0, req.time_ms);
        end
        if (step_results.size() > 0)
            step_results[step_results.size()-1].is_last = 1'b1;
    endfunction

    function automatic vec_t frame_row(input logic is_input, input logic [7:0] rnum,
                                       input logic [7:0] len, input logic [7:0] tag,
                                       input logic [31:0] t, input check_mode_e mode);
        vec_t v;
        v.kind         = ~KIND_READ;
        v.req          = '0;
        v.req.is_input = is_input;
        v.req.rnum     = rnum;
        v.req.len      = len;
        v.req.tag      = tag;
        v.req.time_ms  = t;
        v.mode         = mode;
        v.typed_val    = '0;
        return v;
    endfunction

    function automatic vec_t read_row(input track_t trk, input stat_sel_t sel,
                                      input check_mode_e mode, input logic [31:0] val);
        vec_t v;
        v.kind         = KIND_READ;
        v.req          = '0;
        v.req.trk_sel  = trk;
        v.req.stat_sel = sel;
        v.mode         = mode;
        v.typed_val    = val;
        return v;
    endfunction

    function automatic void make_random(output logic kind, output req_t req);
        int roll;
        req  = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (($urandom_range(0, 99)) < 5)
            cur_time = cur_time + $urandom;
        else
            cur_time = cur_time + $urandom_range(0, 1500);
        req.time_ms = cur_time;
        kind = ~KIND_READ;
        if (roll < 15)
        begin
            kind = KIND_READ;
            if ($urandom_range(0, 99) < 90)
            begin
                req.trk_sel  = track_t'($urandom_range(0, NUM_TRACKS - 1));
                req.stat_sel = stat_sel_t'($urandom_range(0, STAT_MAX_GAP));
            end
        end
        else
        begin
            req.is_input = 1'b1;
            req.rnum     = ACCEPT_RNUM;
            req.len      = 8'($urandom_range(MIN_FRAME_LEN, 255));
            if ($urandom_range(0, 9) == 0)
                req.tag = TAG_PROX_OUT;
            else
            begin
                req.tag = req.tag & ~TAG_BIT4;
                if ((req.tag & TAG_HI_MASK) == TAG_OOR_HI)
                    req.tag = req.tag ^ 8'h40;
            end
            if (roll < 27)
            begin
                // break one acceptance condition
                case ($urandom_range(0, 4))
                    0: req.is_input = 1'b0;
                    1: req.rnum     = req.rnum ^ 8'($urandom_range(1, 255));
                    2: req.len      = 8'($urandom_range(0, MIN_FRAME_LEN - 1));
                    3: req.tag      = (req.tag & ~TAG_HI_MASK) | TAG_OOR_HI;
                    default: req.tag = req.tag | TAG_BIT4;
                endcase
            end
        end
    endfunction

    task automatic push_request(input logic kind, input req_t req, input check_mode_e mode,
                                input logic [31:0] typed_val);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        req_count++;
        predict_gaps(kind, req);
        if (mode == CHK_MODEL)
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        else if (mode == CHK_READ)
        begin
            r.is_stat = 1'b1;
            r.trk     = '0;
            r.down    = 1'b0;
            r.dur     = '0;
            r.val     = typed_val;
            r.is_last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input int idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        bkt_edges[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_edges(input edge_set_t e);
        for (int i = 0; i < NUM_EDGES; i++)
            cfg_write(i, e[i]);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (expected_results.size() == 0)
                report($sformatf("result with nothing pending, tdata %0h", m_tdata));
            else
            begin
                want_res = expected_results.pop_front();
                if (want_res.is_stat)
                    read_count++;
                else
                    event_count++;
                if (m_tuser !== want_res.is_stat)
                    report($sformatf("is_stat exp %0h got %0h", want_res.is_stat, m_tuser));
                if (m_tdata[2:0] !== want_res.trk)
                    report($sformatf("event_track exp %0h got %0h", want_res.trk,
                                     m_tdata[2:0]));
                if (m_tdata[3] !== want_res.down)
                    report($sformatf("went_down exp %0h got %0h", want_res.down, m_tdata[3]));
                if (m_tdata[35:4] !== want_res.dur)
                    report($sformatf("duration_ms exp %0h got %0h", want_res.dur,
                                     m_tdata[35:4]));
                if (m_tdata[67:36] !== want_res.val)
                    report($sformatf("stat_value exp %0h got %0h", want_res.val,
                                     m_tdata[67:36]));
                if (m_tlast !== want_res.is_last)
                    report($sformatf("last exp %0h got %0h", want_res.is_last, m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic        kind;
        req_t        req;
        edge_set_t   eset;
        int          idle_tab  [NUM_PHASES];
        int          stall_tab [NUM_PHASES];

        idle_tab  = '{0, 64, 0, 10, 0};
        stall_tab = '{0, 0, 64, 10, 0};
        gap_reset();

        directed.push_back(read_row(0, 0, CHK_READ, 0));
        directed.push_back(read_row(PROX_TRACK, STAT_MAX_GAP, CHK_READ, 0));
        directed.push_back(read_row(7, 15, CHK_READ, 0));
        directed.push_back(read_row(6, 3, CHK_READ, 0));
        directed.push_back(frame_row(0, ACCEPT_RNUM, 8, 8'h41, 10, CHK_NONE));
        directed.push_back(frame_row(1, 8'h03, 8, 8'h41, 10, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 1, 8'h41, 10, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 0, 8'h41, 10, CHK_NONE));
        directed.push_back(frame_row(1, 8'hFF, 8'hFF, 8'hFF, 10, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 8, 8'hB5, 10, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 8, TAG_BIT4, 10, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 2, 8'h00, 5, CHK_MODEL));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 2, 8'h20, 6, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 255, 8'h4F, 100, CHK_MODEL));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 9, TAG_PROX_OUT, 200, CHK_MODEL));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 9, TAG_PROX_OUT, 201, CHK_NONE));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 9, 8'hEF, 32'hFFFF_FFFF, CHK_MODEL));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 9, 8'h00, 3, CHK_MODEL));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 9, 8'h4F, 1500, CHK_MODEL));
        directed.push_back(frame_row(1, ACCEPT_RNUM, 9, 8'h80, 32'h7000_0000, CHK_MODEL));
        directed.push_back(read_row(0, STAT_RELEASES, CHK_MODEL, 0));
        directed.push_back(read_row(0, STAT_REASSERTS, CHK_MODEL, 0));
        directed.push_back(read_row(PROX_TRACK, STAT_MAX_GAP, CHK_MODEL, 0));
        directed.push_back(read_row(0, 6, CHK_MODEL, 0));
        directed.push_back(read_row(PROX_TRACK, 0, CHK_MODEL, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            push_request(directed[i].kind, directed[i].req, directed[i].mode,
                         directed[i].typed_val);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: eset = EDGE_RESET;
                1: eset = '0;
                2: eset = '1;
                3: for (int i = 0; i < NUM_EDGES; i++)
                       eset[i] = 16'($urandom_range(0, 1500));
                default: eset = {16'd700, 16'd200, 16'd60, 16'd30, 16'd10, 16'd5};
            endcase
            load_edges(eset);
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            if (p == NUM_PHASES - 1)
                hold_left = HOLD_LEN;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                make_random(kind, req);
                push_request(kind, req, CHK_MODEL, 0);
            end
            drain();
        end

        if (expected_results.size() != 0)
            report($sformatf("%0d results never arrived", expected_results.size()));
        $display("covered %0d requests over %0d edge settings and idle patterns", req_count,
                 NUM_PHASES + 1);
        $display("checked %0d results: %0d track events, %0d statistic reads", result_count,
                 event_count, read_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
